// File: hw/rtl/sgm_pkg.sv
package sgm_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 1024;
	localparam int unsigned MAX_HEIGHT_DEF = 4096;

	localparam int unsigned PIX_W    = 8;
	localparam int unsigned FW_W     = 11;
	localparam int unsigned FH_W     = 13;
	localparam int unsigned CFG_W    = 13;
	localparam int unsigned COL_W    = 10;
	localparam int unsigned ROW_W    = 12;
	localparam int unsigned GRAD_W   = 12;  // signed, |grad| <= 1020
	localparam int unsigned SQ_W     = 20;  // one square
	localparam int unsigned ENERGY_W = 21;  // sum of two squares
	localparam int unsigned ROOT_STEPS = (ENERGY_W + 1) / 2;
	localparam int unsigned STEP_W     = $clog2(ROOT_STEPS + 1);

	localparam logic CFG_FRAME_WIDTH  = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

	typedef struct packed {
		logic [PIX_W-1:0] upper;
		logic [PIX_W-1:0] middle;
	} line_pair_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_START,
		ST_ROOT,
		ST_EMIT
	} state_t;

endpackage

// File: hw/rtl/sgm_line_mem.sv
module sgm_line_mem #(
	parameter int unsigned DEPTH = sgm_pkg::MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output sgm_pkg::line_pair_t      rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  sgm_pkg::line_pair_t      wr_data
);

	sgm_pkg::line_pair_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/sgm_isqrt.sv
module sgm_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sgm_pkg::ENERGY_W-1:0]  radicand,
	output logic                          done,
	output logic [sgm_pkg::PIX_W-1:0]     root
);

	localparam int unsigned EW = sgm_pkg::ENERGY_W;
	localparam logic [EW-1:0] TOP_BIT = EW'(1) << (2 * (sgm_pkg::ROOT_STEPS - 1));

	logic [EW-1:0] v_q, res_q, bit_q;
	logic [sgm_pkg::STEP_W-1:0] steps_q;
	logic busy_q, done_q;
	logic [EW-1:0] trial;

	assign trial = res_q + bit_q;
	assign done  = done_q;
	assign root  = res_q[sgm_pkg::PIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				steps_q <= sgm_pkg::STEP_W'(sgm_pkg::ROOT_STEPS);
			end else if (busy_q) begin
				steps_q <= steps_q - 1'b1;
				if (steps_q == sgm_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one result bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= TOP_BIT;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

// File: hw/rtl/sobel_gradient_magnitude_top.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    pixel, frame_start
// output    out        out_valid/out_ready  magnitude, out_col, out_row, last
// config    in         cfg_we               cfg_index, cfg_data
//
// One pixel request at a time: read at accept, gradients in READ, squares in
// MUL, root start in START, root in ROOT (11 iterations, one root bit each,
// then done), then one result per cycle while out_ready is high; 0..3 results
// per pixel. The bit-serial square root takes the longest.
// Both line buffers share one memory word per column, read at accept and
// written back in the next cycle. Reset clears counters and the window; the
// line memory is not cleared. A stalled result holds the block out of IDLE.
module sobel_gradient_magnitude_top #(
	parameter int unsigned MAX_WIDTH  = sgm_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = sgm_pkg::MAX_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [sgm_pkg::PIX_W-1:0]    pixel,
	input  logic                         frame_start,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sgm_pkg::PIX_W-1:0]    magnitude,
	output logic [sgm_pkg::COL_W-1:0]    out_col,
	output logic [sgm_pkg::ROW_W-1:0]    out_row,
	output logic                         last,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [sgm_pkg::CFG_W-1:0]    cfg_data
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);
	localparam int unsigned GW = sgm_pkg::GRAD_W;

	// config registers
	logic [sgm_pkg::FW_W-1:0] frame_width_q;
	logic [sgm_pkg::FH_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= sgm_pkg::FRAME_WIDTH_RST;
			frame_height_q <= sgm_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sgm_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[sgm_pkg::FW_W-1:0];
				sgm_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sgm_pkg::state_t state_q, state_d;
	logic accept, out_take;
	assign accept   = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	// position of the incoming pixel and the counters after it
	logic [CW-1:0] col_q, res_col_q, wlast_q;
	logic [RW-1:0] row_q, res_row_q;
	logic [31:0] w_i, h_i, cp, rp, cn, rn;
	logic f0, f1, f2, fmag;

	always_comb begin
		w_i = 32'(frame_width_q);
		if (w_i < 32'd3) w_i = 32'd3;
		else if (w_i > MAX_WIDTH) w_i = MAX_WIDTH;
		h_i = 32'(frame_height_q);
		if (h_i < 32'd3) h_i = 32'd3;
		else if (h_i > MAX_HEIGHT) h_i = MAX_HEIGHT;

		cp = frame_start ? 32'd0 : 32'(col_q);
		rp = frame_start ? 32'd0 : 32'(row_q);
		if (cp >= w_i) begin
			cp = 32'd0;
			rp = rp + 32'd1;
		end
		if (rp >= h_i) rp = 32'd0;

		cn = cp + 32'd1;
		rn = rp;
		if (cn >= w_i) begin
			cn = 32'd0;
			rn = rp + 32'd1;
			if (rn >= h_i) rn = 32'd0;
		end

		f0   = (rp >= 32'd1) && (cp >= 32'd1);
		f1   = (rp >= 32'd1) && (cp == w_i - 32'd1);
		f2   = (rp == h_i - 32'd1);
		fmag = (rp >= 32'd2) && (cp >= 32'd2);
	end

	// latched request
	logic [sgm_pkg::PIX_W-1:0] px_q;
	logic [2:0] pend_q;
	logic mag_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (accept) begin
			col_q  <= CW'(cn);
			row_q  <= RW'(rn);
			pend_q <= {f2, f1, f0};
		end else if (out_take) begin
			// drop the lowest pending result
			pend_q <= pend_q & (pend_q - 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q      <= pixel;
			res_col_q <= CW'(cp);
			res_row_q <= RW'(rp);
			wlast_q   <= CW'(w_i - 32'd1);
			mag_en_q  <= fmag;
		end
	end

	// line memory: read at accept, write back shifted column in READ
	sgm_pkg::line_pair_t rd_data, wr_data;
	assign wr_data.upper  = rd_data.middle;
	assign wr_data.middle = px_q;

	sgm_line_mem #(.DEPTH(MAX_WIDTH)) u_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (CW'(cp)),
		.rd_data (rd_data),
		.wr_en   (state_q == sgm_pkg::ST_READ),
		.wr_addr (res_col_q),
		.wr_data (wr_data)
	);

	// window: [0..2] column c-2, [3..5] column c-1 (top, middle, bottom)
	logic [sgm_pkg::PIX_W-1:0] win_q [6];
	logic signed [GW-1:0] dx, dy;
	logic signed [GW-1:0] dx_s2, dy_s2;

	function automatic logic signed [GW-1:0] ext(input logic [sgm_pkg::PIX_W-1:0] p);
		return $signed({{(GW - sgm_pkg::PIX_W){1'b0}}, p});
	endfunction

	always_comb begin
		dx = ext(win_q[0]) + (ext(win_q[3]) <<< 1) + ext(rd_data.upper)
			- ext(win_q[2]) - (ext(win_q[5]) <<< 1) - ext(px_q);
		dy = ext(win_q[0]) - ext(rd_data.upper)
			+ (ext(win_q[1]) <<< 1) - (ext(rd_data.middle) <<< 1)
			+ ext(win_q[2]) - ext(px_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (state_q == sgm_pkg::ST_READ) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= rd_data.upper;
			win_q[4] <= rd_data.middle;
			win_q[5] <= px_q;
		end
	end

	logic [sgm_pkg::SQ_W-1:0] sqx_s3, sqy_s3;
	logic signed [2*GW-1:0] sqx_full, sqy_full;
	assign sqx_full = dx_s2 * dx_s2;
	assign sqy_full = dy_s2 * dy_s2;

	always_ff @(posedge clk) begin
		if (state_q == sgm_pkg::ST_READ) begin
			dx_s2 <= dx;
			dy_s2 <= dy;
		end
		if (state_q == sgm_pkg::ST_MUL) begin
			sqx_s3 <= sqx_full[sgm_pkg::SQ_W-1:0];
			sqy_s3 <= sqy_full[sgm_pkg::SQ_W-1:0];
		end
	end

	logic root_done;
	logic [sgm_pkg::PIX_W-1:0] root;

	sgm_isqrt u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == sgm_pkg::ST_START),
		.radicand ({1'b0, sqx_s3} + {1'b0, sqy_s3}),
		.done     (root_done),
		.root     (root)
	);

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sgm_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			sgm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = sgm_pkg::ST_READ;
			end
			sgm_pkg::ST_READ:  state_d = sgm_pkg::ST_MUL;
			sgm_pkg::ST_MUL:   state_d = sgm_pkg::ST_START;
			sgm_pkg::ST_START: state_d = sgm_pkg::ST_ROOT;
			sgm_pkg::ST_ROOT: begin
				if (root_done) begin
					state_d = (pend_q != 3'd0) ? sgm_pkg::ST_EMIT : sgm_pkg::ST_IDLE;
				end
			end
			sgm_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready && last) state_d = sgm_pkg::ST_IDLE;
			end
			default: state_d = sgm_pkg::ST_IDLE;
		endcase
	end

	// result fields follow the lowest pending flag
	always_comb begin
		last = (pend_q & (pend_q - 3'd1)) == 3'd0;
		if (pend_q[0]) begin
			magnitude = mag_en_q ? root : '0;
			out_col   = sgm_pkg::COL_W'(res_col_q - 1'b1);
			out_row   = sgm_pkg::ROW_W'(res_row_q - 1'b1);
		end else if (pend_q[1]) begin
			magnitude = '0;
			out_col   = sgm_pkg::COL_W'(wlast_q);
			out_row   = sgm_pkg::ROW_W'(res_row_q - 1'b1);
		end else begin
			magnitude = '0;
			out_col   = sgm_pkg::COL_W'(res_col_q);
			out_row   = sgm_pkg::ROW_W'(res_row_q);
		end
	end

endmodule

// File: hw/rtl/sgm_checker.sv
module sgm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [sgm_pkg::PIX_W-1:0]  magnitude,
	input logic [sgm_pkg::COL_W-1:0]  out_col,
	input logic [sgm_pkg::ROW_W-1:0]  out_row,
	input logic                       last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(magnitude)
			&& $stable(out_col) && $stable(out_row) && $stable(last))
		else $error("result changed while stalled");

	// one pixel at a time: no new request while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while results pending");

	// first column is always a border
	a_border_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_col == '0 |-> magnitude == '0)
		else $error("nonzero magnitude on first column");

	// results of one pixel come back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside a result burst");

	// input is refused right after a request is taken
	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken too early");

endmodule

bind sobel_gradient_magnitude_top sgm_checker u_sgm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.magnitude (magnitude),
	.out_col   (out_col),
	.out_row   (out_row),
	.last      (last)
);
